[hdl/cdtod_pkg.sv]
// Shared types, constants and helper functions for the civil date to time of day core.
// Used by cdtod_calc, civil_date_to_time_of_day_core and cdtod_checker.
package cdtod_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SPAN  = 2'd2
    } cdtod_status_t;

    // Input request fields, laid out so that year sits in the lowest bits.
    typedef struct packed {
        logic [15:0] millisecond;
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] year;
    } cdtod_in_t;

    typedef struct packed {
        logic [15:0]   days_since_epoch;
        logic [26:0]   day_ms;
        cdtod_status_t status;
    } cdtod_res_t;

    localparam int IN_WIDTH  = 72;
    localparam int OUT_WIDTH = 80;

    localparam logic [15:0] YEAR_MIN       = 16'd1970;
    localparam logic [7:0]  MONTH_MAX      = 8'd12;
    localparam logic [7:0]  DAY_MAX        = 8'd31;
    localparam logic [7:0]  HOUR_MAX       = 8'd23;
    localparam logic [7:0]  MINUTE_MAX     = 8'd59;
    localparam logic [7:0]  SECOND_MAX     = 8'd60;
    localparam logic [15:0] MILLI_MAX      = 16'd999;
    localparam logic [7:0]  MONTH_FEB      = 8'd2;

    localparam logic [26:0] MS_PER_HOUR    = 27'd3600000;
    localparam logic [26:0] MS_PER_MINUTE  = 27'd60000;
    localparam logic [26:0] MS_PER_SECOND  = 27'd1000;
    localparam logic [26:0] MS_DAY_MAX     = 27'd86400999;

    // Day number of 1984-01-01 on the same scale as cdtod_calc.
    localparam logic [24:0] EPOCH_DAY_NUM  = 25'd724581;
    localparam logic [24:0] DAYS_PER_YEAR  = 25'd365;
    localparam logic [28:0] DIV100_MUL     = 29'd5243;
    localparam int          DIV100_SHIFT   = 19;

    // Day of the March-based year on which each month starts.
    function automatic logic [8:0] month_offset(input logic [7:0] month);
        logic [8:0] offs;
        unique case (month)
            8'd3:    offs = 9'd0;
            8'd4:    offs = 9'd31;
            8'd5:    offs = 9'd61;
            8'd6:    offs = 9'd92;
            8'd7:    offs = 9'd122;
            8'd8:    offs = 9'd153;
            8'd9:    offs = 9'd184;
            8'd10:   offs = 9'd214;
            8'd11:   offs = 9'd245;
            8'd12:   offs = 9'd275;
            8'd1:    offs = 9'd306;
            8'd2:    offs = 9'd337;
            default: offs = 9'd0;
        endcase
        return offs;
    endfunction

endpackage

[hdl/cdtod_calc.sv]
// Combinational range check, day count and millisecond-of-day conversion for one request.
// Depends on cdtod_pkg.
module cdtod_calc
    import cdtod_pkg::*;
(
    input  cdtod_in_t  item,
    output cdtod_res_t result
);

    logic        range_bad;
    logic [15:0] yy;
    logic [28:0] cent_prod;
    logic [9:0]  cent;
    logic [8:0]  doy;
    logic [24:0] day_num;
    logic [24:0] day_rel;
    logic        span_bad;
    logic [26:0] ms_sum;

    assign range_bad = (item.year < YEAR_MIN) || (item.month == 8'd0) ||
                       (item.month > MONTH_MAX) || (item.day == 8'd0) ||
                       (item.day > DAY_MAX) || (item.hour > HOUR_MAX) ||
                       (item.minute > MINUTE_MAX) || (item.second > SECOND_MAX) ||
                       (item.millisecond > MILLI_MAX);

    // January and February count with the previous year.
    assign yy = item.year - ((item.month <= MONTH_FEB) ? 16'd1 : 16'd0);

    // The reciprocal product gives the exact quotient by 100 below 43690; larger years
    // lie so far past the day span that an error of one cannot change the outcome.
    assign cent_prod = 29'(yy) * DIV100_MUL;
    assign cent      = cent_prod[DIV100_SHIFT +: 10];

    assign doy = month_offset(item.month) + 9'(item.day) - 9'd1;

    assign day_num = 25'(yy) * DAYS_PER_YEAR + 25'(yy[15:2]) - 25'(cent)
                   + 25'(cent[9:2]) + 25'(doy);
    assign day_rel  = day_num - EPOCH_DAY_NUM;
    assign span_bad = (day_num < EPOCH_DAY_NUM) || (day_rel[24:16] != 9'd0);

    assign ms_sum = 27'(item.hour) * MS_PER_HOUR + 27'(item.minute) * MS_PER_MINUTE
                  + 27'(item.second) * MS_PER_SECOND + 27'(item.millisecond);

    always_comb
    begin
        result.status           = ST_OK;
        result.day_ms           = '0;
        result.days_since_epoch = '0;
        if (range_bad)
        begin
            result.status = ST_RANGE;
        end
        else if (span_bad)
        begin
            result.status = ST_SPAN;
        end
        else
        begin
            result.day_ms           = ms_sum;
            result.days_since_epoch = day_rel[15:0];
        end
    end

endmodule

[hdl/civil_date_to_time_of_day_core.sv]
// Top level of the civil date to time of day core: input register, conversion, result register.
// Depends on cdtod_pkg and cdtod_calc.
//
// Usage:
// A request on the s_axis channel carries a UTC date and time. Each request gives exactly
// one result on the m_axis channel with a status, the milliseconds since midnight, the
// days since 1984-01-01 and the producer interval held in the configuration register.
// The user must write the register through cfg_wr_en and cfg_wr_data only while the core is idle;
// the core itself does not enforce this. The request is captured in an input register,
// converted by one pass of logic in cdtod_calc and captured in the result register once
// that register is free. One request is accepted every cycle while results are taken.
// If the receiver holds m_axis_tready low, the result stays on the port and the input
// register keeps one more request; s_axis_tready falls once both are full.
// Reset clears both valid flags and the interval register; no result is pending after it.
module civil_date_to_time_of_day_core
    import cdtod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // year[15:0], month[23:16], day[31:24], hour[39:32], minute[47:40],
    // second[55:48], millisecond[71:56]
    input  logic [IN_WIDTH-1:0]  s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status[1:0], day_ms[28:2], days_since_epoch[44:29], interval_ms[76:45], zero[79:77]
    output logic [OUT_WIDTH-1:0] m_axis_tdata
);

    logic [31:0] interval_reg;
    logic [31:0] interval_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    cdtod_in_t   in_data_reg;
    cdtod_in_t   in_data_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    cdtod_res_t  out_res_reg;
    cdtod_res_t  out_res_next;
    logic [31:0] out_interval_reg;
    logic [31:0] out_interval_next;
    cdtod_res_t  calc_res;
    logic        out_load;
    logic        in_load;

    cdtod_calc u_calc (
        .item   (in_data_reg),
        .result (calc_res)
    );

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        interval_next     = cfg_wr_en ? cfg_wr_data : interval_reg;
        in_valid_next     = in_valid_reg;
        in_data_next      = in_data_reg;
        out_valid_next    = out_valid_reg;
        out_res_next      = out_res_reg;
        out_interval_next = out_interval_reg;
        if (out_load)
        begin
            out_valid_next    = in_valid_reg;
            out_res_next      = calc_res;
            out_interval_next = interval_reg;
            in_valid_next     = 1'b0;
        end
        if (in_load)
        begin
            in_valid_next = 1'b1;
            in_data_next  = cdtod_in_t'(s_axis_tdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            interval_reg  <= interval_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg      <= in_data_next;
        out_res_reg      <= out_res_next;
        out_interval_reg <= out_interval_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_interval_reg, out_res_reg.days_since_epoch,
                            out_res_reg.day_ms, out_res_reg.status};

endmodule

[hdl/cdtod_checker.sv]
// Port-level checks on the result channel of the civil date to time of day core.
// Depends on cdtod_pkg; bound to civil_date_to_time_of_day_core below.
module cdtod_checker
    import cdtod_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_WIDTH-1:0] m_axis_tdata
);

    logic [1:0]  chk_status;
    logic [26:0] chk_ms;
    logic [15:0] chk_days;

    assign chk_status = m_axis_tdata[1:0];
    assign chk_ms     = m_axis_tdata[28:2];
    assign chk_days   = m_axis_tdata[44:29];

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("Result pending during reset.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (chk_status != ST_OK)) |-> ((chk_ms == 27'd0) && (chk_days == 16'd0)))
        else $error("Refused request carries nonzero time fields.");

    a_ms_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (chk_status == ST_OK)) |-> (chk_ms <= MS_DAY_MAX))
        else $error("Milliseconds of day out of range.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled result changed or vanished.");

endmodule

bind civil_date_to_time_of_day_core cdtod_checker u_cdtod_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
